/* rtl/core/kbd_pkg.sv */
`timescale 1ns / 1ps

package kbd_pkg;

    localparam int SLOT_PORTS = 6;
    localparam int KEY_SLOTS  = 6;
    localparam int EVT_COUNT  = 1 + 2 * KEY_SLOTS;

    typedef logic [7:0] code_t;
    typedef logic [KEY_SLOTS-1:0][7:0] key_row_t;
    typedef logic [EVT_COUNT-1:0] evt_mask_t;

    localparam code_t KEY_EMPTY    = 8'd0;
    localparam code_t KEY_ROLLOVER = 8'd1;

    typedef enum logic [1:0] {
        KIND_MODS = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2
    } kind_t;

    typedef struct packed {
        logic down;
        logic up;
    } lane_flags_t;

    typedef struct packed {
        evt_mask_t mask;
        key_row_t  cur_keys;
        key_row_t  prior_keys;
        code_t     old_mods;
        code_t     new_mods;
    } job_t;

endpackage

/* rtl/core/kbd_lane.sv */
`timescale 1ns / 1ps

module kbd_lane
    import kbd_pkg::*;
(
    input  code_t       cur_code,
    input  code_t       prior_code,
    input  key_row_t    cur_row,
    input  key_row_t    prior_row,
    output lane_flags_t flags
);

    logic cur_seen;
    logic prior_seen;

    always_comb
    begin
        cur_seen   = 1'b0;
        prior_seen = 1'b0;
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            if (prior_row[k] == cur_code)
            begin
                cur_seen = 1'b1;
            end
            if (cur_row[k] == prior_code)
            begin
                prior_seen = 1'b1;
            end
        end
        flags.down = (cur_code > KEY_ROLLOVER) && !cur_seen;
        flags.up   = (prior_code > KEY_ROLLOVER) && !prior_seen;
    end

endmodule

/* rtl/core/kbd_serializer.sv */
`timescale 1ns / 1ps

module kbd_serializer
    import kbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_load,
    input  job_t       job_in,
    output logic       job_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_kind,
    output logic [7:0] key_code,
    output logic [7:0] old_modifiers,
    output logic [7:0] new_modifiers,
    output logic       last_event
);

    logic      job_valid_reg;
    evt_mask_t mask_reg;
    evt_mask_t mask_next;
    evt_mask_t low_bit;
    key_row_t  cur_keys_reg;
    key_row_t  prior_keys_reg;
    code_t     old_mods_reg;
    code_t     new_mods_reg;
    logic      load_out;

    logic      out_valid_reg;
    kind_t     kind_reg;
    code_t     code_reg;
    code_t     old_out_reg;
    code_t     new_out_reg;
    logic      last_reg;

    kind_t     sel_kind;
    code_t     sel_code;

    always_comb
    begin
        low_bit   = mask_reg & (~mask_reg + 1'b1);
        mask_next = mask_reg & ~low_bit;
        load_out  = job_valid_reg && (!out_valid_reg || out_ready);
        job_ready = !job_valid_reg || (load_out && (mask_next == '0));
    end

    // one-hot pick of the lowest pending event
    always_comb
    begin
        sel_kind = KIND_MODS;
        sel_code = KEY_EMPTY;
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            if (low_bit[1 + 2 * k])
            begin
                sel_kind = KIND_DOWN;
                sel_code = cur_keys_reg[k];
            end
            if (low_bit[2 + 2 * k])
            begin
                sel_kind = KIND_UP;
                sel_code = prior_keys_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            mask_reg      <= '0;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            mask_reg      <= job_in.mask;
        end
        else if (load_out)
        begin
            job_valid_reg <= (mask_next != '0);
            mask_reg      <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            cur_keys_reg   <= job_in.cur_keys;
            prior_keys_reg <= job_in.prior_keys;
            old_mods_reg   <= job_in.old_mods;
            new_mods_reg   <= job_in.new_mods;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            kind_reg    <= sel_kind;
            code_reg    <= sel_code;
            old_out_reg <= old_mods_reg;
            new_out_reg <= new_mods_reg;
            last_reg    <= (mask_next == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign key_code      = code_reg;
    assign old_modifiers = old_out_reg;
    assign new_modifiers = new_out_reg;
    assign last_event    = last_reg;

endmodule

/* rtl/core/keyboard_report_key_event_diff.sv */
`timescale 1ns / 1ps
// first event of a report: after its transfer it is held in the job register, then in the output register
// throughput: one event per cycle while out_ready does not stall the output register
// the next report is taken in the cycle its predecessor's last event moves to the output
// a report that causes no event is taken without entering the event queue
// reset: asynchronous active low, clears prior report to zero and empties the queue

module keyboard_report_key_event_diff
    import kbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] modifier_bits,
    input  logic [7:0] key_slot_0,
    input  logic [7:0] key_slot_1,
    input  logic [7:0] key_slot_2,
    input  logic [7:0] key_slot_3,
    input  logic [7:0] key_slot_4,
    input  logic [7:0] key_slot_5,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_kind,
    output logic [7:0] key_code,
    output logic [7:0] old_modifiers,
    output logic [7:0] new_modifiers,
    output logic       last_event
);

    code_t       prior_mods_reg;
    key_row_t    prior_keys_reg;
    code_t       all_keys [SLOT_PORTS];
    key_row_t    cur_row;
    lane_flags_t flags [KEY_SLOTS];
    evt_mask_t   mask;
    job_t        job;
    logic        in_xfer;
    logic        job_load;
    logic        job_ready;

    assign all_keys[0] = key_slot_0;
    assign all_keys[1] = key_slot_1;
    assign all_keys[2] = key_slot_2;
    assign all_keys[3] = key_slot_3;
    assign all_keys[4] = key_slot_4;
    assign all_keys[5] = key_slot_5;

    always_comb
    begin
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            cur_row[k] = all_keys[k];
        end
    end

    for (genvar g = 0; g < KEY_SLOTS; g++)
    begin : g_lane
        kbd_lane u_lane (
            .cur_code   (cur_row[g]),
            .prior_code (prior_keys_reg[g]),
            .cur_row    (cur_row),
            .prior_row  (prior_keys_reg),
            .flags      (flags[g])
        );
    end

    // merge lane results into the event mask in emission order
    always_comb
    begin
        mask    = '0;
        mask[0] = (modifier_bits != prior_mods_reg);
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            mask[1 + 2 * k] = flags[k].down;
            mask[2 + 2 * k] = flags[k].up;
        end
        job.mask       = mask;
        job.cur_keys   = cur_row;
        job.prior_keys = prior_keys_reg;
        job.old_mods   = prior_mods_reg;
        job.new_mods   = modifier_bits;
    end

    assign in_ready = job_ready;
    assign in_xfer  = in_valid && job_ready;
    assign job_load = in_xfer && (mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_mods_reg <= '0;
            prior_keys_reg <= '0;
        end
        else if (in_xfer)
        begin
            prior_mods_reg <= modifier_bits;
            prior_keys_reg <= cur_row;
        end
    end

    kbd_serializer u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_load      (job_load),
        .job_in        (job),
        .job_ready     (job_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .key_code      (key_code),
        .old_modifiers (old_modifiers),
        .new_modifiers (new_modifiers),
        .last_event    (last_event)
    );

endmodule

/* tb/tb_keyboard_report_key_event_diff.sv */
`timescale 1ns / 1ps

module tb_keyboard_report_key_event_diff;
    import kbd_pkg::*;

    typedef struct packed {
        code_t                        mods;
        logic [SLOT_PORTS-1:0][7:0]   keys;
    } report_t;

    typedef struct packed {
        kind_t kind;
        code_t code;
        code_t old_mods;
        code_t new_mods;
        logic  last;
    } key_event_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] modifier_bits = 8'd0;
    logic [7:0] key_slot_0 = 8'd0;
    logic [7:0] key_slot_1 = 8'd0;
    logic [7:0] key_slot_2 = 8'd0;
    logic [7:0] key_slot_3 = 8'd0;
    logic [7:0] key_slot_4 = 8'd0;
    logic [7:0] key_slot_5 = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] event_kind;
    logic [7:0] key_code;
    logic [7:0] old_modifiers;
    logic [7:0] new_modifiers;
    logic       last_event;

    report_t    pending_reports[$];
    key_event_t expected_events[$];
    code_t      held_mods = KEY_EMPTY;
    code_t      held_keys[SLOT_PORTS];
    logic       report_taken = 1'b0;
    logic       event_taken = 1'b0;
    int         in_gap = 0;
    int         in_calm = 0;
    int         out_gap = 0;
    int         out_calm = 0;
    int         errors = 0;

    keyboard_report_key_event_diff DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .modifier_bits (modifier_bits),
        .key_slot_0    (key_slot_0),
        .key_slot_1    (key_slot_1),
        .key_slot_2    (key_slot_2),
        .key_slot_3    (key_slot_3),
        .key_slot_4    (key_slot_4),
        .key_slot_5    (key_slot_5),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .key_code      (key_code),
        .old_modifiers (old_modifiers),
        .new_modifiers (new_modifiers),
        .last_event    (last_event)
    );

    always #10 clk = ~clk;

    function automatic bit code_held(code_t c, code_t row[SLOT_PORTS]);
        for (int k = 0; k < KEY_SLOTS; k++)
            if (row[k] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic predict_key_events(input report_t rep);
        key_event_t evs[$];
        code_t      cur[SLOT_PORTS];
        code_t      p;
        for (int k = 0; k < SLOT_PORTS; k++)
            cur[k] = (k < KEY_SLOTS) ? rep.keys[k] : KEY_EMPTY;
        if (rep.mods != held_mods)
            evs.push_back(key_event_t'{KIND_MODS, KEY_EMPTY, held_mods, rep.mods, 1'b0});
        for (int k = 0; k < KEY_SLOTS; k++) begin
            p = held_keys[k];
            if (cur[k] > KEY_ROLLOVER && !code_held(cur[k], held_keys))
                evs.push_back(key_event_t'{KIND_DOWN, cur[k], held_mods, rep.mods, 1'b0});
            if (p > KEY_ROLLOVER && !code_held(p, cur))
                evs.push_back(key_event_t'{KIND_UP, p, held_mods, rep.mods, 1'b0});
        end
        if (evs.size() != 0)
            evs[evs.size()-1].last = 1'b1;
        foreach (evs[i])
            expected_events.push_back(evs[i]);
        held_mods = rep.mods;
        held_keys = cur;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            errors++;
        end
    endtask

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(8, 30);
        return $urandom_range(0, 11);
    endfunction

    task automatic add_report(input code_t m, input code_t k0, input code_t k1,
                              input code_t k2, input code_t k3, input code_t k4,
                              input code_t k5);
        report_t rep;
        rep.mods = m;
        rep.keys = {k5, k4, k3, k2, k1, k0};
        pending_reports.push_back(rep);
    endtask

    function automatic code_t pick_code();
        case ($urandom_range(0, 7))
            0, 1:    return KEY_EMPTY;
            2:       return KEY_ROLLOVER;
            3:       return code_t'($urandom_range(2, 255));
            default: return code_t'($urandom_range(2, 12));
        endcase
    endfunction

    // report driver
    always @(negedge clk) begin : drive_reports
        report_t rep;
        if (rst_n && (!in_valid || report_taken)) begin
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (pending_reports.size() != 0) begin
                rep = pending_reports.pop_front();
                in_valid      <= 1'b1;
                modifier_bits <= rep.mods;
                key_slot_0    <= rep.keys[0];
                key_slot_1    <= rep.keys[1];
                key_slot_2    <= rep.keys[2];
                key_slot_3    <= rep.keys[3];
                key_slot_4    <= rep.keys[4];
                key_slot_5    <= rep.keys[5];
                in_gap = draw_wait(in_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // event sink stalls
    always @(negedge clk) begin
        if (rst_n) begin
            if (event_taken)
                out_gap = draw_wait(out_calm);
            if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin : watch_transfers
        report_t    rep;
        key_event_t want;
        report_taken <= in_valid && in_ready;
        event_taken  <= out_valid && out_ready;
        if (rst_n && in_valid && in_ready) begin
            rep.mods = modifier_bits;
            rep.keys = {key_slot_5, key_slot_4, key_slot_3, key_slot_2, key_slot_1,
                        key_slot_0};
            predict_key_events(rep);
        end
        if (rst_n && out_valid && out_ready) begin
            if (expected_events.size() == 0) begin
                $error("unexpected event kind %0d code %0h", event_kind, key_code);
                errors++;
            end else begin
                want = expected_events.pop_front();
                check_field("event_kind", 8'(want.kind), 8'(event_kind));
                check_field("key_code", want.code, key_code);
                check_field("old_modifiers", want.old_mods, old_modifiers);
                check_field("new_modifiers", want.new_mods, new_modifiers);
                check_field("last_event", 8'(want.last), 8'(last_event));
            end
        end
    end

    initial begin : stimulus
        report_t last_rep;
        report_t rep;
        foreach (held_keys[k])
            held_keys[k] = KEY_EMPTY;

        add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_report(8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07);
        add_report(8'h00, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07);
        add_report(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
        add_report(8'h01, 8'h00, 8'h01, 8'h04, 8'h00, 8'h00, 8'h80);
        add_report(8'h01, 8'h80, 8'h00, 8'h00, 8'h04, 8'h01, 8'h00);
        add_report(8'h80, 8'hFE, 8'h02, 8'h80, 8'h00, 8'h00, 8'h00);
        add_report(8'h55, 8'h10, 8'h10, 8'h20, 8'h00, 8'h00, 8'h00);
        add_report(8'hAA, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10);
        add_report(8'h7F, 8'h01, 8'h02, 8'h00, 8'h01, 8'h03, 8'h00);
        add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

        last_rep = '0;
        for (int i = 0; i < 400; i++) begin
            rep = last_rep;
            case ($urandom_range(0, 9))
                0: begin
                    rep.mods = code_t'($urandom_range(0, 255));
                    for (int k = 0; k < SLOT_PORTS; k++)
                        rep.keys[k] = code_t'($urandom_range(0, 255));
                end
                1: ;
                default: begin
                    if ($urandom_range(0, 2) == 0)
                        rep.mods[$urandom_range(0, 7)] ^= 1'b1;
                    for (int k = 0; k < SLOT_PORTS; k++)
                        if ($urandom_range(0, 2) == 0)
                            rep.keys[k] = pick_code();
                end
            endcase
            pending_reports.push_back(rep);
            last_rep = rep;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reports.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
